FILE: sv/smpq_pkg.sv
// ----------------------------------------------------------------------------
// smpq_pkg: shared types and constants of the stable min priority queue
// operation codes, cell control and fixed field widths
// ----------------------------------------------------------------------------
`default_nettype none

package smpq_pkg;

   localparam int PRIO_W     = 64;
   localparam int OP_W       = 2;
   localparam int RSP_DATA_W = 16;
   localparam int REQ_DATA_W = PRIO_W + RSP_DATA_W;
   localparam int RSP_USER_W = 3;

   // request operation codes, the fourth code is a no-op
   typedef enum logic [OP_W-1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PEEK = 2'd2
   } op_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic push;
      logic pop;
   } cell_ctrl_type;

endpackage

`default_nettype wire

FILE: sv/smpq_cell.sv
// ----------------------------------------------------------------------------
// smpq_cell: one slot of the sorted chain
// holds one entry, compares it with the pushed key and shifts with neighbors
// ----------------------------------------------------------------------------
`default_nettype none

module smpq_cell
   import smpq_pkg::*;
#(
   parameter int PAYLOAD_BITS = 16
) (
   input  wire logic                    clock,
   input  wire cell_ctrl_type           ctrl,
   input  wire logic                    occupied,
   input  wire logic [PRIO_W-1:0]       new_prio,
   input  wire logic [PAYLOAD_BITS-1:0] new_payload,
   input  wire logic                    left_le,
   input  wire logic [PRIO_W-1:0]       left_prio,
   input  wire logic [PAYLOAD_BITS-1:0] left_payload,
   input  wire logic [PRIO_W-1:0]       right_prio,
   input  wire logic [PAYLOAD_BITS-1:0] right_payload,
   output logic                         self_le,
   output logic [PRIO_W-1:0]            prio,
   output logic [PAYLOAD_BITS-1:0]      payload
);

   logic [PRIO_W-1:0]       prio_ff, prio_in;
   logic [PAYLOAD_BITS-1:0] payload_ff, payload_in;

   // an empty slot counts as larger than any key
   assign self_le = occupied && (prio_ff <= new_prio);

   always_comb begin
      prio_in    = prio_ff;
      payload_in = payload_ff;
      if (ctrl.push && !self_le) begin
         if (left_le) begin
            prio_in    = new_prio;
            payload_in = new_payload;
         end else begin
            prio_in    = left_prio;
            payload_in = left_payload;
         end
      end else if (ctrl.pop) begin
         prio_in    = right_prio;
         payload_in = right_payload;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff    <= prio_in;
      payload_ff <= payload_in;
   end

   assign prio    = prio_ff;
   assign payload = payload_ff;

endmodule

`default_nettype wire

FILE: sv/stable_min_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_min_priority_queue: sorted insertion priority queue
// a row of cells kept in priority order, head at cell zero, stable for ties
// ----------------------------------------------------------------------------
//
//  channel  direction  tdata                             tuser
//  req      in         priority[63:0], payload[79:64]    op[1:0]
//  rsp      out        result_payload[15:0]              valid, empty, dropped
//
//  one request per cycle unless a stalled response holds req_tready low: every
//  cell compares against the pushed key at once and all cells shift in the same edge
//  the response is registered and appears the cycle after the request
//  req_tready stays high while the response register is free or being taken
//  reset empties the queue by clearing the entry count only
//  a stalled response holds, and the next request waits behind it
// ----------------------------------------------------------------------------
`default_nettype none

module stable_min_priority_queue
   import smpq_pkg::*;
#(
   parameter int DEPTH        = 16,
   parameter int PAYLOAD_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // priority[63:0], payload[79:64]
   input  wire logic [OP_W-1:0]       req_tuser,  // op[1:0]
   // response channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // result_payload[15:0]
   output logic [RSP_USER_W-1:0]      rsp_tuser   // result_valid, queue_empty, push_dropped
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   // entry count and occupancy
   logic [CNT_W-1:0] count_ff, count_in;
   logic             is_empty, is_full;
   logic [DEPTH-1:0] occupied;

   // request decode
   logic                    accept;
   op_type                  op;
   logic [PRIO_W-1:0]       req_prio;
   logic [PAYLOAD_BITS-1:0] req_payload;
   logic [63:0]             req_payload_ext;
   cell_ctrl_type           ctrl;

   // chain taps
   logic [PRIO_W-1:0]       cell_prio    [DEPTH];
   logic [PAYLOAD_BITS-1:0] cell_payload [DEPTH];
   logic [DEPTH-1:0]        cell_le;
   logic [63:0]             head_ext;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;
   logic                  res_valid, res_empty, res_dropped;

   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CNT_W'(DEPTH));

   // response register frees up when taken, so requests keep flowing
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign op              = op_type'(req_tuser);
   assign req_prio        = req_tdata[PRIO_W-1:0];
   assign req_payload_ext = 64'(req_tdata[REQ_DATA_W-1:PRIO_W]);
   assign req_payload     = req_payload_ext[PAYLOAD_BITS-1:0];

   assign head_ext = 64'(cell_payload[0]);

   // commands and response fields
   always_comb begin
      ctrl        = '0;
      res_valid   = 1'b0;
      res_dropped = 1'b0;
      res_empty   = is_empty;
      count_in    = count_ff;
      case (op)
         OP_PUSH: begin
            if (is_full) begin
               res_dropped = 1'b1;
            end else begin
               ctrl.push = accept;
               res_empty = 1'b0;
               if (accept) count_in = count_ff + 1'b1;
            end
         end
         OP_POP: begin
            if (!is_empty) begin
               ctrl.pop  = accept;
               res_valid = 1'b1;
               res_empty = (count_ff == CNT_W'(1));
               if (accept) count_in = count_ff - 1'b1;
            end
         end
         OP_PEEK: begin
            res_valid = !is_empty;
         end
         default: begin
         end
      endcase
   end

   // row of cells, each sees its left and right neighbor
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [PRIO_W-1:0]       left_prio, right_prio;
      logic [PAYLOAD_BITS-1:0] left_payload, right_payload;
      logic                    left_le;

      assign occupied[i] = (count_ff > CNT_W'(i));

      if (i == 0) begin : g_head
         // nothing ahead of the head, a push that reaches it lands here
         assign left_le      = 1'b1;
         assign left_prio    = '0;
         assign left_payload = '0;
      end else begin : g_body
         assign left_le      = cell_le[i-1];
         assign left_prio    = cell_prio[i-1];
         assign left_payload = cell_payload[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_prio    = '0;
         assign right_payload = '0;
      end else begin : g_inner
         assign right_prio    = cell_prio[i+1];
         assign right_payload = cell_payload[i+1];
      end

      smpq_cell #(
         .PAYLOAD_BITS(PAYLOAD_BITS)
      ) u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .occupied     (occupied[i]),
         .new_prio     (req_prio),
         .new_payload  (req_payload),
         .left_le      (left_le),
         .left_prio    (left_prio),
         .left_payload (left_payload),
         .right_prio   (right_prio),
         .right_payload(right_payload),
         .self_le      (cell_le[i]),
         .prio         (cell_prio[i]),
         .payload      (cell_payload[i])
      );
   end

   // response register next values
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_valid ? head_ext[RSP_DATA_W-1:0] : '0;
         rsp_user_in  = {res_dropped, res_empty, res_valid};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

FILE: sv/smpq_check.sv
// ----------------------------------------------------------------------------
// smpq_check: port checker for the stable min priority queue
// watches the response channel for consistent flags and held data
// ----------------------------------------------------------------------------
`default_nettype none

module smpq_check
   import smpq_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [RSP_USER_W-1:0] rsp_tuser
);

   // stalled response holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // a found head and a dropped push never come together
   a_valid_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[2]))
      else $error("result valid with push dropped");

   // payload is zero unless a head was found
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("payload without valid result");

   // a dropped push means the queue is full, so not empty
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> !rsp_tuser[1])
      else $error("push dropped on empty queue");

endmodule

bind stable_min_priority_queue smpq_check u_smpq_check (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);

`default_nettype wire

FILE: bench/stable_min_priority_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stable_min_priority_queue_tb: self-checking bench for the sorted queue
// a directed table covers the empty, full, tie and extreme-key cases, then
// random push / pop / peek / no-op traffic in fill, drain and mixed phases; each
// response is checked against its typed row or an in-bench sorted-list model of the queue
// ----------------------------------------------------------------------------

module stable_min_priority_queue_tb;
   import smpq_pkg::*;

   localparam int QUEUE_DEPTH  = 16;
   localparam int TAG_W        = 16;
   localparam int RANDOM_COUNT = 800;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;

   // the fourth op code does nothing
   localparam logic [OP_W-1:0] OP_NOP = 2'd3;

   // rsp_tuser bit positions, lowest first
   localparam int USER_VALID   = 0;
   localparam int USER_EMPTY   = 1;
   localparam int USER_DROPPED = 2;

   // traffic phases of the random part
   typedef enum int {
      PHASE_FILL,
      PHASE_DRAIN,
      PHASE_MIXED
   } phase_type;

   typedef struct packed {
      logic              result_valid;
      logic [TAG_W-1:0]  result_payload;
      logic              queue_empty;
      logic              push_dropped;
   } queue_result_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [PRIO_W-1:0] key;
      logic [TAG_W-1:0]  tag;
      logic              typed;  // expected response typed in below
      queue_result_type  want;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // priority[63:0], payload[79:64]
   logic [OP_W-1:0]       req_tuser;   // op[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // result_payload[15:0]
   logic [RSP_USER_W-1:0] rsp_tuser;   // result_valid, queue_empty, push_dropped

   // model of the queue contents, head at index zero
   logic [PRIO_W-1:0] model_key [QUEUE_DEPTH];
   logic [TAG_W-1:0]  model_tag [QUEUE_DEPTH];
   int unsigned       model_count;

   queue_result_type pending_results[$];
   stim_row_type     directed_rows[$];
   int unsigned      error_count;
   int unsigned      cycle_count;
   int unsigned      rsp_taken;       // bumped on every accepted response
   int unsigned      rsp_taken_seen;
   int unsigned      rsp_stall_left;
   bit               no_idle;         // both sides run back to back while set

   stable_min_priority_queue #(
      .DEPTH        (QUEUE_DEPTH),
      .PAYLOAD_BITS (TAG_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // apply one request to the model and return the response it should give
   function automatic queue_result_type queue_step(logic [OP_W-1:0] op,
                                                   logic [PRIO_W-1:0] key,
                                                   logic [TAG_W-1:0] tag);
      queue_result_type r;
      int unsigned      slot;
      r = '0;
      if (op == OP_PUSH) begin
         if (model_count >= QUEUE_DEPTH) begin
            r.push_dropped = 1'b1;
         end else begin
            // stable insert: go behind every key less than or equal
            slot = 0;
            while (slot < model_count && model_key[slot] <= key) slot++;
            for (int i = model_count; i > slot; i--) begin
               model_key[i] = model_key[i-1];
               model_tag[i] = model_tag[i-1];
            end
            model_key[slot] = key;
            model_tag[slot] = tag;
            model_count++;
         end
      end else if ((op == OP_POP || op == OP_PEEK) && model_count > 0) begin
         r.result_valid   = 1'b1;
         r.result_payload = model_tag[0];
         if (op == OP_POP) begin
            for (int i = 1; i < model_count; i++) begin
               model_key[i-1] = model_key[i];
               model_tag[i-1] = model_tag[i];
            end
            model_count--;
         end
      end
      r.queue_empty = (model_count == 0);
      return r;
   endfunction

   function automatic stim_row_type plain_row(logic [OP_W-1:0] op, logic [PRIO_W-1:0] key,
                                              logic [TAG_W-1:0] tag);
      stim_row_type row;
      row     = '0;
      row.op  = op;
      row.key = key;
      row.tag = tag;
      return row;
   endfunction

   function automatic stim_row_type typed_row(logic [OP_W-1:0] op, logic [PRIO_W-1:0] key,
                                              logic [TAG_W-1:0] tag, logic valid,
                                              logic [TAG_W-1:0] payload, logic empty,
                                              logic dropped);
      stim_row_type row;
      row       = plain_row(op, key, tag);
      row.typed = 1'b1;
      row.want  = '{valid, payload, empty, dropped};
      return row;
   endfunction

   function automatic int unsigned idle_draw();
      return no_idle ? 0 : $urandom_range(0, 5);
   endfunction

   // one request: idle gap, present at the falling edge, hold until taken
   task automatic send_request(stim_row_type row);
      int unsigned      gap;
      queue_result_type predicted;
      gap = idle_draw();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {row.tag, row.key};
      req_tuser  <= row.op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // model runs at acceptance so its order matches the block's
      predicted = queue_step(row.op, row.key, row.tag);
      pending_results.push_back(row.typed ? row.want : predicted);
   endtask

   // response side: after each taken response stall for a drawn number of cycles
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_taken != rsp_taken_seen) begin
            rsp_taken_seen = rsp_taken;
            rsp_stall_left = idle_draw();
         end
         if (rsp_stall_left > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // response checker and run watchdog
   always @(posedge clock) begin
      queue_result_type want;
      if (!reset) begin
         cycle_count++;
         if (rsp_tvalid && rsp_tready) begin
            rsp_taken++;
            if (pending_results.size() == 0) begin
               $error("response with no request pending: tdata %h tuser %b",
                      rsp_tdata, rsp_tuser);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_tuser[USER_VALID] !== want.result_valid) begin
                  $error("result_valid expected %0d got %0d",
                         want.result_valid, rsp_tuser[USER_VALID]);
                  error_count++;
               end
               if (rsp_tdata !== want.result_payload) begin
                  $error("result_payload expected %h got %h",
                         want.result_payload, rsp_tdata);
                  error_count++;
               end
               if (rsp_tuser[USER_EMPTY] !== want.queue_empty) begin
                  $error("queue_empty expected %0d got %0d",
                         want.queue_empty, rsp_tuser[USER_EMPTY]);
                  error_count++;
               end
               if (rsp_tuser[USER_DROPPED] !== want.push_dropped) begin
                  $error("push_dropped expected %0d got %0d",
                         want.push_dropped, rsp_tuser[USER_DROPPED]);
                  error_count++;
               end
            end
         end
         if (cycle_count > CYCLE_LIMIT) begin
            $display("stable_min_priority_queue_tb: errors");
            $finish;
         end
      end
   end

   // random priority: heavy on ties and on both ends of the key range
   function automatic logic [PRIO_W-1:0] random_key();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4,
         5:       return PRIO_W'($urandom_range(0, 7));
         6:       return '1 - PRIO_W'($urandom_range(0, 3));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      phase_type     phase;
      int unsigned   phase_left;
      int unsigned   pick;
      logic [OP_W-1:0] op;

      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = OP_NOP;
      rsp_tready     = 1'b0;
      error_count    = 0;
      cycle_count    = 0;
      rsp_taken      = 0;
      rsp_taken_seen = 0;
      rsp_stall_left = 0;
      no_idle        = 1'b0;
      model_count    = 0;

      // empty queue: nothing to pop or peek, no-op reports empty
      directed_rows.push_back(typed_row(OP_POP,  '0, '0, 1'b0, '0, 1'b1, 1'b0));
      directed_rows.push_back(typed_row(OP_PEEK, '0, '0, 1'b0, '0, 1'b1, 1'b0));
      directed_rows.push_back(typed_row(OP_NOP,  '1, '1, 1'b0, '0, 1'b1, 1'b0));
      // extreme keys and tags: the zero key overtakes the all-ones key
      directed_rows.push_back(typed_row(OP_PUSH, '1, '1, 1'b0, '0, 1'b0, 1'b0));
      directed_rows.push_back(typed_row(OP_PUSH, '0, '0, 1'b0, '0, 1'b0, 1'b0));
      directed_rows.push_back(typed_row(OP_PEEK, '0, '0, 1'b1, 16'h0000, 1'b0, 1'b0));
      directed_rows.push_back(typed_row(OP_POP,  '0, '0, 1'b1, 16'h0000, 1'b0, 1'b0));
      directed_rows.push_back(typed_row(OP_POP,  '0, '0, 1'b1, 16'hffff, 1'b1, 1'b0));
      // fill to the brim with ties in scrambled order
      directed_rows.push_back(plain_row(OP_PUSH, 64'd7, 16'h0001));
      directed_rows.push_back(plain_row(OP_PUSH, 64'd3, 16'h0002));
      directed_rows.push_back(plain_row(OP_PUSH, 64'd7, 16'h0003));
      directed_rows.push_back(plain_row(OP_PUSH, 64'd3, 16'h0004));
      directed_rows.push_back(plain_row(OP_PUSH, '1,    16'h0005));
      directed_rows.push_back(plain_row(OP_PUSH, 64'd0, 16'h0006));
      directed_rows.push_back(plain_row(OP_PUSH, 64'd5, 16'h0007));
      directed_rows.push_back(plain_row(OP_PUSH, 64'd5, 16'h0008));
      directed_rows.push_back(plain_row(OP_PUSH, 64'd5, 16'h0009));
      directed_rows.push_back(plain_row(OP_PUSH, 64'd1, 16'h000a));
      directed_rows.push_back(plain_row(OP_PUSH, 64'd7, 16'h000b));
      directed_rows.push_back(plain_row(OP_PUSH, 64'd3, 16'h000c));
      directed_rows.push_back(plain_row(OP_PUSH, 64'd2, 16'h000d));
      directed_rows.push_back(plain_row(OP_PUSH, 64'd2, 16'h000e));
      directed_rows.push_back(plain_row(OP_PUSH, '1,    16'h000f));
      directed_rows.push_back(plain_row(OP_PUSH, 64'd0, 16'h0010));
      // full queue: push is dropped, no-op leaves it alone
      directed_rows.push_back(typed_row(OP_PUSH, 64'd0, 16'hbeef, 1'b0, '0, 1'b0, 1'b1));
      directed_rows.push_back(typed_row(OP_NOP,  '0, '0, 1'b0, '0, 1'b0, 1'b0));
      directed_rows.push_back(plain_row(OP_PEEK, '0, '0));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_request(directed_rows[i]);

      // random traffic in phases so the queue swings between empty and full
      phase      = PHASE_DRAIN;
      phase_left = 0;
      for (int n = 0; n < RANDOM_COUNT; n++) begin
         if (phase_left == 0) begin
            phase      = phase_type'($urandom_range(0, 2));
            phase_left = $urandom_range(20, 60);
            no_idle    = ($urandom_range(0, 3) == 0);
         end
         phase_left--;
         pick = $urandom_range(0, 99);
         case (phase)
            PHASE_FILL:  op = pick < 70 ? OP_PUSH : pick < 85 ? OP_POP :
                              pick < 95 ? OP_PEEK : OP_NOP;
            PHASE_DRAIN: op = pick < 20 ? OP_PUSH : pick < 75 ? OP_POP :
                              pick < 95 ? OP_PEEK : OP_NOP;
            default:     op = pick < 45 ? OP_PUSH : pick < 80 ? OP_POP :
                              pick < 95 ? OP_PEEK : OP_NOP;
         endcase
         send_request(plain_row(op, random_key(), TAG_W'($urandom)));
      end

      @(negedge clock);
      req_tvalid <= 1'b0;

      // let the last responses drain, the watchdog bounds this wait
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("stable_min_priority_queue_tb: clean");
      end else begin
         $display("stable_min_priority_queue_tb: errors");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/smpq_pkg.sv
sv/smpq_cell.sv
sv/stable_min_priority_queue.sv
sv/smpq_check.sv
bench/stable_min_priority_queue_tb.sv
